/* hdl/wsfd_pkg.sv */
// Package for the WebSocket frame deframer.
// Holds the parse phase type, error codes, frame kinds and the opcode decoder.
// No dependencies.
package wsfd_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned LenWidth  = 16;
    localparam int unsigned KeyWidth  = 32;
    localparam int unsigned KindWidth = 3;
    localparam int unsigned ErrWidth  = 2;

    localparam logic [LenWidth-1:0] MaxPayloadReset = 16'hFFFF;

    localparam logic [6:0] Len7Ext16 = 7'd126;
    localparam logic [6:0] Len7Ext64 = 7'd127;

    localparam logic [ErrWidth-1:0] ErrNone     = 2'd0;
    localparam logic [ErrWidth-1:0] ErrLen64    = 2'd1;
    localparam logic [ErrWidth-1:0] ErrTooLarge = 2'd2;
    localparam logic [ErrWidth-1:0] ErrOpcode   = 2'd3;

    localparam logic [3:0] OpCont   = 4'h0;
    localparam logic [3:0] OpText   = 4'h1;
    localparam logic [3:0] OpBinary = 4'h2;
    localparam logic [3:0] OpClose  = 4'h8;
    localparam logic [3:0] OpPing   = 4'h9;
    localparam logic [3:0] OpPong   = 4'hA;

    localparam logic [KindWidth-1:0] KindCont   = 3'd0;
    localparam logic [KindWidth-1:0] KindText   = 3'd1;
    localparam logic [KindWidth-1:0] KindBinary = 3'd2;
    localparam logic [KindWidth-1:0] KindClose  = 3'd3;
    localparam logic [KindWidth-1:0] KindPing   = 3'd4;
    localparam logic [KindWidth-1:0] KindPong   = 3'd5;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic                 known;
        logic [KindWidth-1:0] kind;
    } kind_dec_t;

    function automatic kind_dec_t kind_of(input logic [3:0] op);
        kind_dec_t r;
        r.known = 1'b1;
        r.kind  = KindCont;
        unique case (op)
            OpCont:   r.kind = KindCont;
            OpText:   r.kind = KindText;
            OpBinary: r.kind = KindBinary;
            OpClose:  r.kind = KindClose;
            OpPing:   r.kind = KindPing;
            OpPong:   r.kind = KindPong;
            default:  r.known = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/wsfd_channels.sv */
// Handshake channels of the WebSocket frame deframer.
// The byte stream channel and the result channel; depends on wsfd_pkg.
interface wsfd_byte_if
    import wsfd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfd_result_if
    import wsfd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] data_byte;
    logic                 has_data;
    logic [KindWidth-1:0] frame_kind;
    logic                 fin_flag;
    logic                 last_of_frame;
    logic [ErrWidth-1:0]  error_code;

    modport source (output valid, output data_byte, output has_data, output frame_kind,
                    output fin_flag, output last_of_frame, output error_code,
                    input ready);
    modport sink (input valid, input data_byte, input has_data, input frame_kind,
                  input fin_flag, input last_of_frame, input error_code,
                  output ready);
endinterface

/* hdl/websocket_frame_deframer_unit.sv */
// WebSocket frame deframer: parses a received byte stream into unmasked payload beats.
// Top level; depends on wsfd_pkg and the channel interfaces in wsfd_channels.sv.
//
// Usage: received bytes enter one per beat on the stream channel. Header bytes
// (first byte, length byte, two extended length bytes, four key bytes) give no
// result. Every payload byte gives one result beat, unmasked, with its frame
// kind, FIN bit and a last-of-frame mark. A zero-length frame gives one marker
// beat without data. A 64-bit length, a length above max_payload or an unknown
// opcode gives one error beat, after which all input is taken and dropped until
// reset. The max_payload register is written with cfg_wr_en and cfg_wr_data;
// the user writes it only while the block is idle; the block does not enforce it.
// Throughput is one byte per cycle while the receiver takes every beat: the parse
// state and the result register are both updated at the edge that accepts a byte,
// so the result beat is on the result channel in the cycle after that edge.
// When the receiver stalls, the result register holds its beat and the stream
// channel stays ready only in the cycle that the held beat is taken.
// Reset clears the parser to wait for a first header byte, drops any held
// result and sets max_payload to 65535.
module websocket_frame_deframer_unit
    import wsfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LenWidth-1:0] cfg_wr_data,
    wsfd_byte_if.sink           stream,
    wsfd_result_if.source       result
);

    phase_t               phase_reg, phase_next;
    logic [1:0]           hcount_reg, hcount_next;
    logic [LenWidth-1:0]  len_reg, len_next;
    logic [LenWidth-1:0]  remain_reg, remain_next;
    logic [KeyWidth-1:0]  key_reg, key_next;
    logic                 masked_reg, masked_next;
    logic [3:0]           opcode_reg, opcode_next;
    logic                 fin_reg, fin_next;
    logic [LenWidth-1:0]  max_payload_reg;

    logic                 res_valid_reg, res_valid_next;
    logic [ByteWidth-1:0] res_data_reg, res_data_next;
    logic                 res_has_reg, res_has_next;
    logic [KindWidth-1:0] res_kind_reg, res_kind_next;
    logic                 res_fin_reg, res_fin_next;
    logic                 res_last_reg, res_last_next;
    logic [ErrWidth-1:0]  res_err_reg, res_err_next;

    logic                 accept;
    logic [ByteWidth-1:0] b;
    logic [LenWidth-1:0]  chk_len;
    logic                 chk_masked;
    logic                 do_check;
    logic                 do_begin;
    logic [1:0]           pos;
    logic [ByteWidth-1:0] key_byte;
    logic [LenWidth-1:0]  remain_dec;
    kind_dec_t            cur_kind;
    kind_dec_t            new_kind;

    assign stream.ready = !res_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.rx_byte;
    assign cur_kind     = kind_of(opcode_reg);
    assign new_kind     = kind_of(opcode_reg);
    assign pos          = len_reg[1:0] - remain_reg[1:0];
    assign remain_dec   = remain_reg - LenWidth'(1);

    always_comb
    begin
        unique case (pos)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        len_next       = len_reg;
        remain_next    = remain_reg;
        key_next       = key_reg;
        masked_next    = masked_reg;
        opcode_next    = opcode_reg;
        fin_next       = fin_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_data_next  = res_data_reg;
        res_has_next   = res_has_reg;
        res_kind_next  = res_kind_reg;
        res_fin_next   = res_fin_reg;
        res_last_next  = res_last_reg;
        res_err_next   = res_err_reg;
        chk_len        = len_reg;
        chk_masked     = masked_reg;
        do_check       = 1'b0;
        do_begin       = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = b[7];
                    opcode_next = b[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = b[7];
                    chk_masked  = b[7];
                    key_next    = '0;
                    len_next    = '0;
                    hcount_next = 2'd0;
                    if (b[6:0] == Len7Ext64)
                    begin
                        phase_next     = PH_ERROR;
                        res_valid_next = 1'b1;
                        res_data_next  = '0;
                        res_has_next   = 1'b0;
                        res_kind_next  = KindCont;
                        res_fin_next   = 1'b0;
                        res_last_next  = 1'b1;
                        res_err_next   = ErrLen64;
                    end
                    else if (b[6:0] == Len7Ext16)
                    begin
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        chk_len  = {{(LenWidth-7){1'b0}}, b[6:0]};
                        len_next = chk_len;
                        do_check = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    chk_len  = {len_reg[7:0], b};
                    len_next = chk_len;
                    if (hcount_reg == 2'd0)
                    begin
                        hcount_next = 2'd1;
                    end
                    else
                    begin
                        hcount_next = 2'd0;
                        do_check    = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], b};
                    if (hcount_reg != 2'd3)
                    begin
                        hcount_next = hcount_reg + 2'd1;
                    end
                    else
                    begin
                        hcount_next = 2'd0;
                        chk_len     = len_reg;
                        do_begin    = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next    = remain_dec;
                    res_valid_next = 1'b1;
                    res_data_next  = b ^ key_byte;
                    res_has_next   = 1'b1;
                    res_kind_next  = cur_kind.kind;
                    res_fin_next   = fin_reg;
                    res_last_next  = (remain_dec == '0);
                    res_err_next   = ErrNone;
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_ERROR:
                begin
                    phase_next = PH_ERROR;
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase

            if (do_check)
            begin
                if (chk_len > max_payload_reg || !new_kind.known)
                begin
                    phase_next     = PH_ERROR;
                    res_valid_next = 1'b1;
                    res_data_next  = '0;
                    res_has_next   = 1'b0;
                    res_kind_next  = KindCont;
                    res_fin_next   = 1'b0;
                    res_last_next  = 1'b1;
                    res_err_next   = (chk_len > max_payload_reg) ? ErrTooLarge : ErrOpcode;
                end
                else if (chk_masked)
                begin
                    hcount_next = 2'd0;
                    phase_next  = PH_MASK;
                end
                else
                begin
                    do_begin = 1'b1;
                end
            end

            if (do_begin)
            begin
                if (chk_len == '0)
                begin
                    phase_next     = PH_HDR0;
                    res_valid_next = 1'b1;
                    res_data_next  = '0;
                    res_has_next   = 1'b0;
                    res_kind_next  = cur_kind.kind;
                    res_fin_next   = fin_reg;
                    res_last_next  = 1'b1;
                    res_err_next   = ErrNone;
                end
                else
                begin
                    remain_next = chk_len;
                    phase_next  = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            hcount_reg      <= '0;
            len_reg         <= '0;
            remain_reg      <= '0;
            key_reg         <= '0;
            masked_reg      <= 1'b0;
            opcode_reg      <= '0;
            fin_reg         <= 1'b0;
            max_payload_reg <= MaxPayloadReset;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hcount_reg    <= hcount_next;
            len_reg       <= len_next;
            remain_reg    <= remain_next;
            key_reg       <= key_next;
            masked_reg    <= masked_next;
            opcode_reg    <= opcode_next;
            fin_reg       <= fin_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        res_has_reg  <= res_has_next;
        res_kind_reg <= res_kind_next;
        res_fin_reg  <= res_fin_next;
        res_last_reg <= res_last_next;
        res_err_reg  <= res_err_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.data_byte     = res_data_reg;
    assign result.has_data      = res_has_reg;
    assign result.frame_kind    = res_kind_reg;
    assign result.fin_flag      = res_fin_reg;
    assign result.last_of_frame = res_last_reg;
    assign result.error_code    = res_err_reg;

`ifndef NO_ASSERTIONS
    // Once the error beat has left, the parser stays silent until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR && !res_valid_reg) |=> !res_valid_reg)
        else $error("result beat produced after the error beat");

    // A result that carries an error code leaves the parser in the error phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_err_reg != ErrNone) |-> phase_reg == PH_ERROR)
        else $error("error beat without the error phase");

    // Every payload byte taken gives a data beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_PAYLOAD) |=> (res_valid_reg && res_has_reg))
        else $error("payload byte gave no data beat");

    // A beat without data is always the last of its frame and has zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_has_reg) |-> (res_last_reg && res_data_reg == '0))
        else $error("marker beat is malformed");
`endif

endmodule
